>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel converter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed: label");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed: label");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed: label");

`endif

>>> src/y2r_pkg.sv
// ---------------------------------------------------------------------------
// y2r_pkg
// Types and fixed-point constants shared by the YUV 4:2:0 to RGB565 blocks.
// ---------------------------------------------------------------------------
package y2r_pkg;

  // Chroma coefficients scaled by 2^CoefShift. With this precision the
  // truncated product matches the exact decimal ratio for every input.
  localparam int CoefShift = 24;
  localparam int CoefWidth = 25;
  localparam int ProdWidth = 32;

  localparam logic [CoefWidth-1:0] COEF_UB = 25'd29729227;  // 1.772
  localparam logic [CoefWidth-1:0] COEF_UG = 25'd5773711;   // 0.34414
  localparam logic [CoefWidth-1:0] COEF_VG = 25'd11981281;  // 0.71414
  localparam logic [CoefWidth-1:0] COEF_VR = 25'd23521657;  // 1.402

  localparam logic [8:0] CHROMA_OFFSET = 9'd128;

  typedef logic [7:0]         sample_t;
  typedef logic signed [9:0]  term_t;
  typedef logic [15:0]        pixel_t;
  typedef logic [31:0]        pair_t;

  // Chroma contributions shared by all four pixels of one block.
  typedef struct packed {
    term_t ub;
    term_t gsum;
    term_t vr;
  } chroma_terms_t;

  // Saturate a signed channel value to 0..255.
  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

>>> src/y2r_if.sv
// ---------------------------------------------------------------------------
// y2r interfaces
// Valid/ready channels for 2x2 YUV block requests and RGB565 pair results.
// ---------------------------------------------------------------------------
interface y2r_in_if;
  logic               valid;
  logic               ready;
  y2r_pkg::sample_t   luma_top_left;
  y2r_pkg::sample_t   luma_top_right;
  y2r_pkg::sample_t   luma_bottom_left;
  y2r_pkg::sample_t   luma_bottom_right;
  y2r_pkg::sample_t   chroma_blue;
  y2r_pkg::sample_t   chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    output ready
  );
endinterface

interface y2r_out_if;
  logic            valid;
  logic            ready;
  y2r_pkg::pair_t  top_pair;
  y2r_pkg::pair_t  bottom_pair;

  modport source (
    output valid, top_pair, bottom_pair,
    input  ready
  );
  modport sink (
    input  valid, top_pair, bottom_pair,
    output ready
  );
endinterface

>>> src/y2r_chroma.sv
// ---------------------------------------------------------------------------
// y2r_chroma
// Two-stage chroma term unit: scaled products, then truncation and sign.
// ---------------------------------------------------------------------------
module y2r_chroma (
  input  logic                    clk,
  input  logic                    en,
  input  y2r_pkg::sample_t        chroma_blue,
  input  y2r_pkg::sample_t        chroma_red,
  output y2r_pkg::chroma_terms_t  terms
);

  localparam int PW = y2r_pkg::ProdWidth;
  localparam int SH = y2r_pkg::CoefShift;

  logic signed [8:0] du;
  logic signed [8:0] dv;
  logic [7:0]        mag_u;
  logic [7:0]        mag_v;

  logic [PW-1:0] prod_ub_r, prod_ug_r, prod_vg_r, prod_vr_r;
  logic          neg_u_r, neg_v_r;

  logic [7:0]    q_ub, q_ug, q_vg, q_vr;
  y2r_pkg::term_t t_ub, t_ug, t_vg, t_vr;
  y2r_pkg::chroma_terms_t terms_r;

  // Offset removal and magnitude of each chroma sample.
  always_comb begin
    du    = $signed({1'b0, chroma_blue}) - $signed(y2r_pkg::CHROMA_OFFSET);
    dv    = $signed({1'b0, chroma_red}) - $signed(y2r_pkg::CHROMA_OFFSET);
    mag_u = du[8] ? 8'(-du) : du[7:0];
    mag_v = dv[8] ? 8'(-dv) : dv[7:0];
  end

  // Stage one: magnitude times the scaled coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_ub_r <= PW'({24'd0, mag_u} * PW'(y2r_pkg::COEF_UB));
      prod_ug_r <= PW'({24'd0, mag_u} * PW'(y2r_pkg::COEF_UG));
      prod_vg_r <= PW'({24'd0, mag_v} * PW'(y2r_pkg::COEF_VG));
      prod_vr_r <= PW'({24'd0, mag_v} * PW'(y2r_pkg::COEF_VR));
      neg_u_r   <= du[8];
      neg_v_r   <= dv[8];
    end
  end

  // Truncate toward zero by dropping the fraction, then restore the sign.
  always_comb begin
    q_ub = prod_ub_r[SH+7:SH];
    q_ug = prod_ug_r[SH+7:SH];
    q_vg = prod_vg_r[SH+7:SH];
    q_vr = prod_vr_r[SH+7:SH];
    t_ub = neg_u_r ? -$signed({2'b00, q_ub}) : $signed({2'b00, q_ub});
    t_ug = neg_u_r ? -$signed({2'b00, q_ug}) : $signed({2'b00, q_ug});
    t_vg = neg_v_r ? -$signed({2'b00, q_vg}) : $signed({2'b00, q_vg});
    t_vr = neg_v_r ? -$signed({2'b00, q_vr}) : $signed({2'b00, q_vr});
  end

  // Stage two: signed terms and the combined green correction.
  always_ff @(posedge clk) begin
    if (en) begin
      terms_r.ub   <= t_ub;
      terms_r.gsum <= t_ug + t_vg;
      terms_r.vr   <= t_vr;
    end
  end

  assign terms = terms_r;

endmodule

>>> src/y2r_lane.sv
// ---------------------------------------------------------------------------
// y2r_lane
// One pixel lane: adds chroma terms to luma, saturates and packs RGB565.
// ---------------------------------------------------------------------------
module y2r_lane (
  input  y2r_pkg::sample_t        luma,
  input  y2r_pkg::chroma_terms_t  terms,
  output y2r_pkg::pixel_t         pixel
);

  logic signed [10:0] y_s;
  logic signed [10:0] b_s, g_s, r_s;
  logic [7:0]         b8, g8, r8;

  // Per-channel sums in a width that holds every overflow case.
  always_comb begin
    y_s = $signed({3'b000, luma});
    b_s = y_s + 11'(terms.ub);
    g_s = y_s - 11'(terms.gsum);
    r_s = y_s + 11'(terms.vr);
    b8  = y2r_pkg::sat8(b_s);
    g8  = y2r_pkg::sat8(g_s);
    r8  = y2r_pkg::sat8(r_s);
  end

  assign pixel = {r8[7:3], g8[7:2], b8[7:3]};

endmodule

>>> src/yuv420_to_rgb565_block_core.sv
// Each accepted request passes stage one, stage two and the output register.
// Throughput: one 2x2 block per cycle unless stalled; the four pixel lanes
// run in parallel behind a shared two-stage chroma multiplier pipeline.
// Backpressure stalls all stages together; in_ch.ready follows out_ch.ready
// whenever the output register is full.
// Reset (synchronous, active low) clears the stage valid bits only.
// ---------------------------------------------------------------------------
// yuv420_to_rgb565_block_core
// Converts one 2x2 YUV 4:2:0 block per request into two RGB565 pixel pairs.
// ---------------------------------------------------------------------------
module yuv420_to_rgb565_block_core (
  input  logic              clk,
  input  logic              rst_n,
  y2r_in_if.sink            in_ch,
  y2r_out_if.source         out_ch
);

  logic en;
  logic s1_vld_r, s2_vld_r, out_vld_r;

  y2r_pkg::sample_t s1_luma_r [4];
  y2r_pkg::sample_t s2_luma_r [4];

  y2r_pkg::chroma_terms_t terms;
  y2r_pkg::pixel_t        pix [4];
  y2r_pkg::pair_t         top_r, bottom_r;

  // The whole pipeline moves when the output register is free or drained.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  // Luma samples travel alongside the chroma pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_luma_r[0] <= in_ch.luma_top_left;
      s1_luma_r[1] <= in_ch.luma_top_right;
      s1_luma_r[2] <= in_ch.luma_bottom_left;
      s1_luma_r[3] <= in_ch.luma_bottom_right;
      s2_luma_r    <= s1_luma_r;
    end
  end

  y2r_chroma u_chroma (
    .clk         (clk),
    .en          (en),
    .chroma_blue (in_ch.chroma_blue),
    .chroma_red  (in_ch.chroma_red),
    .terms       (terms)
  );

  // Four pixel lanes share the same chroma terms.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    y2r_lane u_lane (
      .luma  (s2_luma_r[i]),
      .terms (terms),
      .pixel (pix[i])
    );
  end

  // Merge the lanes into row words in the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      top_r    <= {pix[1], pix[0]};
      bottom_r <= {pix[3], pix[2]};
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.top_pair    = top_r;
  assign out_ch.bottom_pair = bottom_r;

endmodule

>>> src/y2r_checker.sv
// ---------------------------------------------------------------------------
// y2r_checker
// Port-level checks of the converter's handshake and reset behavior.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module y2r_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input y2r_pkg::pair_t  top_pair,
  input y2r_pkg::pair_t  bottom_pair
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // A stalled result stays put until it is taken.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(top_pair) && $stable(bottom_pair))

  // With the output register empty, a request is always taken.
  `ASSERT_IMPLIES(a_idle_ready, clk, rst_n, !out_valid, in_ready)

  // A draining output also frees the input side in the same cycle.
  `ASSERT_IMPLIES(a_drain_ready, clk, rst_n, out_valid && out_ready, in_ready)

  // A pending request is only refused while a result is stalled.
  `ASSERT_IMPLIES(a_refuse_stall, clk, rst_n, in_valid && !in_ready, out_stall)

  // Reset empties the pipeline.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind yuv420_to_rgb565_block_core y2r_checker u_y2r_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .top_pair    (out_ch.top_pair),
  .bottom_pair (out_ch.bottom_pair)
);
